// ===== src/rmvs_pkg.sv =====
// types and constants shared by the running statistics block
package rmvs_pkg;

  // fraction bits of the sample format; the arithmetic itself does not depend on it
  localparam int FRAC_BITS = 16;

  typedef struct packed {
    logic               action;
    logic signed [31:0] sample;
  } in_item_t;

  typedef struct packed {
    logic        [31:0] sample_count;
    logic signed [63:0] value_sum;
    logic signed [31:0] running_mean;
    logic        [62:0] unbiased_variance;
    logic signed [31:0] largest;
    logic signed [31:0] smallest;
  } out_item_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_UPDATE,
    ST_MDIV_START,
    ST_MDIV_WAIT,
    ST_MEAN,
    ST_MUL,
    ST_ACC,
    ST_VDIV_START,
    ST_VDIV_WAIT,
    ST_OUT
  } state_t;

  // commands from controller to datapath
  typedef struct packed {
    logic load;
    logic update;
    logic mdiv_start;
    logic mean;
    logic mul;
    logic acc;
    logic vdiv_start;
    logic vdiv_take;
  } cmd_t;

  typedef struct packed {
    logic first;
    logic clear;
    logic div_done;
  } status_t;

endpackage

// ===== src/rmvs_div.sv =====
// iterative unsigned restoring divider, one quotient bit per cycle
module rmvs_div (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [63:0] dividend,
  input  logic [31:0] divisor,
  output logic        done,
  output logic [63:0] quotient
);

  logic [63:0] q_r, q_nxt;
  logic [32:0] rem_r, rem_nxt;
  logic [31:0] d_r, d_nxt;
  logic [6:0]  cnt_r, cnt_nxt;
  logic        busy_r, busy_nxt;
  logic        done_r, done_nxt;
  logic [33:0] trial;
  logic [32:0] shifted;

  always_comb begin
    shifted  = {rem_r[31:0], q_r[63]};
    trial    = {1'b0, shifted} - {2'b00, d_r};
    q_nxt    = q_r;
    rem_nxt  = rem_r;
    d_nxt    = d_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      q_nxt    = dividend;
      rem_nxt  = '0;
      d_nxt    = divisor;
      cnt_nxt  = 7'd64;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (!trial[33]) begin
        rem_nxt = trial[32:0];
        q_nxt   = {q_r[62:0], 1'b1};
      end else begin
        rem_nxt = shifted;
        q_nxt   = {q_r[62:0], 1'b0};
      end
      cnt_nxt = cnt_r - 7'd1;
      if (cnt_r == 7'd1) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    q_r   <= q_nxt;
    rem_r <= rem_nxt;
    d_r   <= d_nxt;
  end

  assign done     = done_r;
  assign quotient = q_r;

endmodule

// ===== src/rmvs_datapath.sv =====
// statistics registers, update arithmetic and shared divider
module rmvs_datapath #(
  parameter int COUNT_WIDTH = 32
) (
  input  logic                clk,
  input  logic                rst_n,
  input  rmvs_pkg::cmd_t      cmd,
  input  rmvs_pkg::in_item_t  in_item,
  output rmvs_pkg::status_t   status,
  output rmvs_pkg::out_item_t result
);

  localparam logic [COUNT_WIDTH-1:0] CountMax = '1;
  localparam logic signed [63:0] SumMax = 64'sh7FFF_FFFF_FFFF_FFFF;
  localparam logic signed [63:0] SumMin = 64'sh8000_0000_0000_0000;

  logic [COUNT_WIDTH-1:0] count_r, count_nxt;
  logic signed [63:0]     sum_r, sum_nxt;
  logic signed [31:0]     mean_r, max_r, min_r;
  logic [63:0]            svar_r;
  logic [62:0]            var_r;
  logic signed [31:0]     x_r;
  logic                   act_r;
  logic signed [32:0]     delta_r, delta2_r;
  logic [63:0]            prod_r;
  logic                   dneg_r;
  logic [63:0]            div_dividend;
  logic [31:0]            div_divisor;
  logic                   div_done;
  logic [63:0]            div_q;
  logic signed [63:0]     sum_add;
  logic signed [32:0]     nm;
  logic signed [32:0]     qs;
  logic [32:0]            dmag;
  logic [64:0]            acc_sum;
  logic [COUNT_WIDTH-1:0] cm1;

  always_comb begin
    count_nxt = (count_r == CountMax) ? count_r : count_r + 1'b1;
    sum_add   = sum_r + 64'(x_r);
    sum_nxt   = sum_add;
    if (x_r > 0 && sum_r > 0 && sum_add < 0) sum_nxt = SumMax;
    if (x_r < 0 && sum_r < 0 && sum_add >= 0) sum_nxt = SumMin;
    dmag      = delta_r[32] ? 33'(-delta_r) : 33'(delta_r);
    qs        = dneg_r ? -$signed(div_q[32:0]) : $signed(div_q[32:0]);
    nm        = 33'(mean_r) + qs;
    acc_sum   = {1'b0, svar_r} + {1'b0, prod_r};
    cm1       = count_r - 1'b1;
    div_dividend = cmd.vdiv_start ? svar_r : {31'b0, dmag};
    div_divisor  = cmd.vdiv_start ? 32'(cm1) : 32'(count_r);
  end

  rmvs_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.mdiv_start | cmd.vdiv_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .done     (div_done),
    .quotient (div_q)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      sum_r   <= '0;
      mean_r  <= '0;
      svar_r  <= '0;
      max_r   <= '0;
      min_r   <= '0;
      var_r   <= '0;
    end else begin
      if (cmd.update) begin
        if (act_r) begin
          count_r <= '0;
          sum_r   <= '0;
          mean_r  <= '0;
          svar_r  <= '0;
          max_r   <= '0;
          min_r   <= '0;
        end else begin
          count_r <= count_nxt;
          sum_r   <= sum_nxt;
          if (count_nxt == COUNT_WIDTH'(1)) begin
            mean_r <= x_r;
            svar_r <= '0;
            max_r  <= x_r;
            min_r  <= x_r;
          end else begin
            if (x_r > max_r) max_r <= x_r;
            if (x_r < min_r) min_r <= x_r;
          end
        end
      end
      if (cmd.mean) mean_r <= nm[31:0];
      if (cmd.acc) svar_r <= acc_sum[64] ? '1 : acc_sum[63:0];
      if (cmd.vdiv_take) var_r <= div_q[62:0];
      if (cmd.update) var_r <= '0;
    end
    if (cmd.load) begin
      x_r   <= in_item.sample;
      act_r <= in_item.action;
    end
    if (cmd.update) begin
      delta_r <= 33'(x_r) - 33'(mean_r);
      dneg_r  <= (33'(x_r) - 33'(mean_r)) < 0;
    end
    if (cmd.mean) delta2_r <= 33'(x_r) - nm;
    if (cmd.mul) prod_r <= 64'(dmag[31:0]) * 64'(delta2_r[32] ? 33'(-delta2_r) : delta2_r);
  end

  assign status.first    = (count_r < COUNT_WIDTH'(2));
  assign status.clear    = act_r;
  assign status.div_done = div_done;

  assign result.sample_count      = 32'(count_r);
  assign result.value_sum         = sum_r;
  assign result.running_mean      = mean_r;
  assign result.unbiased_variance = var_r;
  assign result.largest           = max_r;
  assign result.smallest          = min_r;

endmodule

// ===== src/rmvs_ctrl.sv =====
// sequencing state machine for one item
module rmvs_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  input  rmvs_pkg::status_t status,
  output rmvs_pkg::cmd_t    cmd
);

  rmvs_pkg::state_t state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      rmvs_pkg::ST_IDLE:       if (in_valid) state_nxt = rmvs_pkg::ST_UPDATE;
      rmvs_pkg::ST_UPDATE:     state_nxt = rmvs_pkg::ST_MDIV_START;
      rmvs_pkg::ST_MDIV_START:
        state_nxt = (status.clear || status.first) ? rmvs_pkg::ST_OUT
                                                   : rmvs_pkg::ST_MDIV_WAIT;
      rmvs_pkg::ST_MDIV_WAIT:  if (status.div_done) state_nxt = rmvs_pkg::ST_MEAN;
      rmvs_pkg::ST_MEAN:       state_nxt = rmvs_pkg::ST_MUL;
      rmvs_pkg::ST_MUL:        state_nxt = rmvs_pkg::ST_ACC;
      rmvs_pkg::ST_ACC:        state_nxt = rmvs_pkg::ST_VDIV_START;
      rmvs_pkg::ST_VDIV_START: state_nxt = rmvs_pkg::ST_VDIV_WAIT;
      rmvs_pkg::ST_VDIV_WAIT:  if (status.div_done) state_nxt = rmvs_pkg::ST_OUT;
      rmvs_pkg::ST_OUT:        if (out_ready) state_nxt = rmvs_pkg::ST_IDLE;
      default:                 state_nxt = rmvs_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd        = '0;
    in_ready   = 1'b0;
    out_valid  = 1'b0;
    unique case (state_r)
      rmvs_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        cmd.load = in_valid;
      end
      rmvs_pkg::ST_UPDATE:     cmd.update = 1'b1;
      // divider starts only when a mean step is needed
      rmvs_pkg::ST_MDIV_START: cmd.mdiv_start = !(status.clear || status.first);
      rmvs_pkg::ST_MEAN:       cmd.mean = 1'b1;
      rmvs_pkg::ST_MUL:        cmd.mul = 1'b1;
      rmvs_pkg::ST_ACC:        cmd.acc = 1'b1;
      rmvs_pkg::ST_VDIV_START: cmd.vdiv_start = 1'b1;
      rmvs_pkg::ST_VDIV_WAIT:  cmd.vdiv_take = status.div_done;
      rmvs_pkg::ST_OUT:        out_valid = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= rmvs_pkg::ST_IDLE;
    else        state_r <= state_nxt;
  end

endmodule

// ===== src/running_mean_variance_stats.sv =====
// top level of the running mean and variance statistics block
// Each item observes one signed fixed-point sample or clears all statistics,
// and yields one result with count, sum, mean, unbiased variance, max and min.
// An observed sample after the first makes two passes through one shared
// 64-step shift-subtract divider (the mean step, then the variance over count
// minus one) before its result is offered; the first sample and a clear skip
// both divisions. One item is in work at a time, and a stalled result holds
// off the input until it is taken.
module running_mean_variance_stats #(
  parameter int COUNT_WIDTH = 32
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  rmvs_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output rmvs_pkg::out_item_t out_data
);

  rmvs_pkg::cmd_t    cmd;
  rmvs_pkg::status_t status;

  rmvs_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .status    (status),
    .cmd       (cmd)
  );

  rmvs_datapath #(
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_dp (
    .clk     (clk),
    .rst_n   (rst_n),
    .cmd     (cmd),
    .in_item (in_data),
    .status  (status),
    .result  (out_data)
  );

endmodule
